/* rtl/core/slsw_pkg.sv */
`timescale 1ns / 1ps
// Package for the solar load switch: widths, codes, reset values and shared types.
// No dependencies.
package slsw_pkg;

	localparam int SAMPLES_PER_BATCH = 200;

	localparam int SAMPLE_W = 10;
	localparam int SUM_W    = 18;
	localparam int TIME_W   = 32;
	localparam int COUNT_W  = 8;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 4;

	localparam logic [SUM_W-1:0]  TRIGGER_SUM_RST  = 18'd151292;
	localparam logic [SUM_W-1:0]  CUTOFF_SUM_RST   = 18'd115270;
	localparam logic [TIME_W-1:0] OFF_DELAY_MS_RST = 32'd600000;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_BUTTON = 2'd1,
		CMD_EVAL   = 2'd2,
		CMD_CUTOFF = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_NORMAL     = 2'd0,
		MODE_PENDING    = 2'd1,
		MODE_FORCED_ON  = 2'd2,
		MODE_FORCED_OFF = 2'd3
	} override_t;

	typedef enum logic [1:0] {
		REG_TRIGGER_SUM  = 2'd0,
		REG_CUTOFF_SUM   = 2'd1,
		REG_OFF_DELAY_MS = 2'd2,
		REG_NONE         = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [SUM_W-1:0]  trigger_sum;
		logic [SUM_W-1:0]  cutoff_sum;
		logic [TIME_W-1:0] off_delay_ms;
	} cfg_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [SAMPLE_W-1:0] adc_sample;
		logic [TIME_W-1:0]   now_ms;
	} item_t;

	typedef struct packed {
		logic             relay_on;
		override_t        override_mode;
		logic [SUM_W-1:0] batch_sum;
	} res_t;

endpackage

/* rtl/core/slsw_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and results.
// Depends on slsw_pkg.
interface slsw_in_if import slsw_pkg::*;;
	logic                valid;
	logic                ready;
	logic [1:0]          cmd;
	logic [SAMPLE_W-1:0] adc_sample;
	logic [TIME_W-1:0]   now_ms;

	modport source (output valid, cmd, adc_sample, now_ms, input ready);
	modport sink   (input valid, cmd, adc_sample, now_ms, output ready);
	modport mon    (input valid, ready, cmd, adc_sample, now_ms);
endinterface

interface slsw_out_if import slsw_pkg::*;;
	logic             valid;
	logic             ready;
	logic             relay_on;
	logic [1:0]       override_mode;
	logic [SUM_W-1:0] batch_sum;

	modport source (output valid, relay_on, override_mode, batch_sum, input ready);
	modport sink   (input valid, relay_on, override_mode, batch_sum, output ready);
	modport mon    (input valid, ready, relay_on, override_mode, batch_sum);
endinterface

/* rtl/core/slsw_cfg.sv */
`timescale 1ns / 1ps
// APB register bank: trigger level, cutoff level and off delay.
// Depends on slsw_pkg.
module slsw_cfg import slsw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_sum  <= TRIGGER_SUM_RST;
			cfg_q.cutoff_sum   <= CUTOFF_SUM_RST;
			cfg_q.off_delay_ms <= OFF_DELAY_MS_RST;
		end else if (wr_en) begin
			case (idx)
				REG_TRIGGER_SUM:  cfg_q.trigger_sum  <= pwdata[SUM_W-1:0];
				REG_CUTOFF_SUM:   cfg_q.cutoff_sum   <= pwdata[SUM_W-1:0];
				REG_OFF_DELAY_MS: cfg_q.off_delay_ms <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TRIGGER_SUM:  prdata = {{(DATA_W-SUM_W){1'b0}}, cfg_q.trigger_sum};
			REG_CUTOFF_SUM:   prdata = {{(DATA_W-SUM_W){1'b0}}, cfg_q.cutoff_sum};
			REG_OFF_DELAY_MS: prdata = cfg_q.off_delay_ms;
			default:          prdata = '0;
		endcase
	end

endmodule

/* rtl/core/slsw_core.sv */
`timescale 1ns / 1ps
// Switch state and per-transaction update: batch accumulator, override mode,
// relay and off timestamp. Depends on slsw_pkg.
module slsw_core import slsw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  item_t item,
	input  logic  adv,
	output res_t  res
);

	override_t          ov_q, ov_d, ov_btn, ov_in;
	logic               relay_q, relay_d;
	logic [SUM_W-1:0]   running_q, running_d, sum_add;
	logic [COUNT_W-1:0] count_q, count_d, cnt_inc;
	logic [SUM_W-1:0]   latched_q, latched_d;
	logic [TIME_W-1:0]  last_off_q, last_off_d, elapsed;
	logic               batch_done, at_trig, below_cut, delay_done;

	assign sum_add    = running_q + {{(SUM_W-SAMPLE_W){1'b0}}, item.adc_sample};
	assign cnt_inc    = count_q + 1'b1;
	assign batch_done = cnt_inc >= COUNT_W'(SAMPLES_PER_BATCH);
	assign at_trig    = latched_q >= cfg.trigger_sum;
	assign below_cut  = latched_q < cfg.cutoff_sum;
	assign elapsed    = item.now_ms - last_off_q;
	assign delay_done = elapsed >= cfg.off_delay_ms;

	always_comb begin
		case (ov_q)
			MODE_NORMAL:     ov_btn = MODE_PENDING;
			MODE_FORCED_ON:  ov_btn = MODE_FORCED_OFF;
			MODE_FORCED_OFF: ov_btn = MODE_FORCED_ON;
			default:         ov_btn = ov_q;
		endcase
	end

	always_comb begin
		ov_d       = ov_q;
		relay_d    = relay_q;
		running_d  = running_q;
		count_d    = count_q;
		latched_d  = latched_q;
		last_off_d = last_off_q;
		ov_in      = (item.cmd == CMD_BUTTON) ? ov_btn : ov_q;
		if (ov_in == MODE_PENDING) begin
			ov_in = at_trig ? MODE_FORCED_OFF : MODE_FORCED_ON;
		end
		case (item.cmd)
			CMD_SAMPLE: begin
				if (batch_done) begin
					latched_d = sum_add;
					running_d = '0;
					count_d   = '0;
				end else begin
					running_d = sum_add;
					count_d   = cnt_inc;
				end
			end
			CMD_BUTTON, CMD_EVAL: begin
				ov_d = ov_in;
				if (below_cut) begin
					relay_d = 1'b0;
					ov_d    = MODE_NORMAL;
				end else if (ov_in == MODE_FORCED_ON) begin
					relay_d = 1'b1;
				end else if (ov_in == MODE_FORCED_OFF) begin
					relay_d = 1'b0;
				end else if (at_trig) begin
					relay_d = 1'b1;
				end else if (delay_done) begin
					relay_d    = 1'b0;
					last_off_d = item.now_ms;
				end
			end
			default: begin
				if (below_cut) begin
					relay_d = 1'b0;
					ov_d    = MODE_NORMAL;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q       <= MODE_NORMAL;
			relay_q    <= 1'b0;
			running_q  <= '0;
			count_q    <= '0;
			latched_q  <= '0;
			last_off_q <= '0;
		end else if (adv) begin
			ov_q       <= ov_d;
			relay_q    <= relay_d;
			running_q  <= running_d;
			count_q    <= count_d;
			latched_q  <= latched_d;
			last_off_q <= last_off_d;
		end
	end

	assign res.relay_on      = relay_d;
	assign res.override_mode = ov_d;
	assign res.batch_sum     = latched_d;

endmodule

/* rtl/core/solar_load_switch_with_override_top.sv */
`timescale 1ns / 1ps
// Solar load switch top: input register, core update and result register.
// Depends on slsw_pkg, slsw_if, slsw_cfg and slsw_core.

// Every input transaction yields one result transaction. A transaction waits in the input
// register, where the switch state is updated and the result computed, and is then shown from
// the result register: one transaction per cycle sustained while out_ch.ready is high, with a
// new transaction taken while a result waits to be taken.
// Batch sums, thresholds and the off-delay timer are compared combinationally in the core.
// The user must write registers over APB only while no transaction is in flight; the block does not enforce this.
module solar_load_switch_with_override_top import slsw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	slsw_in_if.sink           in_ch,
	slsw_out_if.source        out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t  cfg;
	item_t item_s1;
	logic  vld_s1;
	res_t  res, res_q;
	logic  out_vld_q;
	logic  adv, in_acc;

	assign adv          = vld_s1 && (!out_vld_q || out_ch.ready);
	assign in_ch.ready  = !vld_s1 || adv;
	assign in_acc       = in_ch.valid && in_ch.ready;

	slsw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	slsw_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.adv    (adv),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.cmd        <= cmd_t'(in_ch.cmd);
			item_s1.adc_sample <= in_ch.adc_sample;
			item_s1.now_ms     <= in_ch.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_ch.valid         = out_vld_q;
	assign out_ch.relay_on      = res_q.relay_on;
	assign out_ch.override_mode = res_q.override_mode;
	assign out_ch.batch_sum     = res_q.batch_sum;

endmodule

/* rtl/core/slsw_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the solar load switch, bound to the top level.
// Depends on slsw_pkg.
module slsw_props import slsw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic             relay_on,
	input  logic [1:0]       override_mode,
	input  logic [SUM_W-1:0] batch_sum
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(relay_on)
		&& $stable(override_mode) && $stable(batch_sum))
		else $error("result changed while stalled");

	// with the result register empty a new transaction is always taken
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// every evaluation settles a pending override
	a_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> override_mode != MODE_PENDING)
		else $error("pending override in result");

	a_forced_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && override_mode == MODE_FORCED_OFF |-> !relay_on)
		else $error("relay on in forced off mode");

	a_forced_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && override_mode == MODE_FORCED_ON |-> relay_on)
		else $error("relay off in forced on mode");

endmodule

bind solar_load_switch_with_override_top slsw_props u_slsw_props (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.relay_on      (out_ch.relay_on),
	.override_mode (out_ch.override_mode),
	.batch_sum     (out_ch.batch_sum)
);
